// ===== hw/rtl/lpd_pkg.sv =====
package lpd_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Event codes on the input channel
  localparam logic [OP_W-1:0] OP_BEGIN  = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
  localparam logic [OP_W-1:0] OP_END    = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_START   = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  // Register indexes (byte address bit 2)
  localparam logic REG_TIME_THR = 1'b0;
  localparam logic REG_MOVE_THR = 1'b1;

  localparam logic [THR_W-1:0] TIME_THR_RST = 16'd750;
  localparam logic [THR_W-1:0] MOVE_THR_RST = 16'd0;

  typedef struct packed {
    logic [THR_W-1:0] time_threshold;
    logic [THR_W-1:0] move_threshold;
  } cfg_t;

endpackage

// ===== hw/rtl/lpd_in_if.sv =====
interface lpd_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    op;
  logic signed [COORD_WIDTH-1:0] x_pos;
  logic signed [COORD_WIDTH-1:0] y_pos;
  logic                          inside_req;
  logic [31:0]                   now_ms;

  modport source (
    output valid, op, x_pos, y_pos, inside_req, now_ms,
    input  ready
  );
  modport sink (
    input  valid, op, x_pos, y_pos, inside_req, now_ms,
    output ready
  );
endinterface

// ===== hw/rtl/lpd_out_if.sv =====
interface lpd_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_kind;
  logic signed [COORD_WIDTH-1:0] event_x;
  logic signed [COORD_WIDTH-1:0] event_y;
  logic                          recognized;

  modport source (
    output valid, event_kind, event_x, event_y, recognized,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_x, event_y, recognized,
    output ready
  );
endinterface

// ===== hw/rtl/lpd_cfg.sv =====
module lpd_cfg
  import lpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_threshold <= TIME_THR_RST;
      cfg.move_threshold <= MOVE_THR_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TIME_THR: cfg.time_threshold <= pwdata[THR_W-1:0];
        REG_MOVE_THR: cfg.move_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIME_THR: prdata = APB_DW'(cfg.time_threshold);
      REG_MOVE_THR: prdata = APB_DW'(cfg.move_threshold);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/lpd_in_stage.sv =====
module lpd_in_stage (
  input logic      clk,
  input logic      rst,
  lpd_in_if.sink   s,
  lpd_in_if.source m
);

  logic valid;

  assign s.ready = !valid || m.ready;
  assign m.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s.ready) begin
      valid <= s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s.valid && s.ready) begin
      m.op         <= s.op;
      m.x_pos      <= s.x_pos;
      m.y_pos      <= s.y_pos;
      m.inside_req <= s.inside_req;
      m.now_ms     <= s.now_ms;
    end
  end

endmodule

// ===== hw/rtl/lpd_core.sv =====
module lpd_core
  import lpd_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  lpd_in_if.sink    s,
  lpd_out_if.source m
);

  localparam int CMP_W = (COORD_WIDTH + 1 > THR_W) ? COORD_WIDTH + 1 : THR_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // press state
  logic              hold_active;
  logic              timing;
  logic [TIME_W-1:0] start_time;
  coord_t            anchor_x;
  coord_t            anchor_y;

  logic              hold_active_next;
  logic              timing_next;
  logic [TIME_W-1:0] start_time_next;
  coord_t            anchor_x_next;
  coord_t            anchor_y_next;

  logic              out_valid;
  logic [KIND_W-1:0] kind_next;
  coord_t            ev_x_next;
  coord_t            ev_y_next;

  logic              advance;
  logic              do_check;
  logic              do_release;
  coord_t            cx;
  coord_t            cy;
  logic              cin;
  logic [COORD_WIDTH:0] dx;
  logic [COORD_WIDTH:0] dy;
  logic [COORD_WIDTH:0] adx;
  logic [COORD_WIDTH:0] ady;
  logic              drift;
  logic [TIME_W-1:0] elapsed;

  assign s.ready  = !out_valid || m.ready;
  assign advance  = s.valid && s.ready;
  assign m.valid  = out_valid;

  always_comb begin
    hold_active_next = hold_active;
    timing_next      = timing;
    start_time_next  = start_time;
    anchor_x_next    = anchor_x;
    anchor_y_next    = anchor_y;
    kind_next        = EV_NONE;
    ev_x_next        = '0;
    ev_y_next        = '0;
    do_check         = 1'b0;
    do_release       = 1'b0;
    cx               = s.x_pos;
    cy               = s.y_pos;
    cin              = 1'b1;

    // decode the event into a press check or a release
    case (s.op)
      OP_BEGIN: begin
        if (s.inside_req) begin
          anchor_x_next = s.x_pos;
          anchor_y_next = s.y_pos;
          do_check      = 1'b1;
        end
      end
      OP_MOVE: begin
        if (s.inside_req) begin
          if (!timing) begin
            anchor_x_next = s.x_pos;
            anchor_y_next = s.y_pos;
          end
          do_check = 1'b1;
        end else begin
          do_release = 1'b1;
        end
      end
      OP_CANCEL, OP_END: do_release = 1'b1;
      OP_TICK: begin
        if (timing) begin
          cx       = anchor_x;
          cy       = anchor_y;
          cin      = s.inside_req;
          do_check = 1'b1;
        end
      end
      default: ;
    endcase

    // drift from the anchor, per axis
    dx  = {cx[COORD_WIDTH-1], cx} - {anchor_x_next[COORD_WIDTH-1], anchor_x_next};
    dy  = {cy[COORD_WIDTH-1], cy} - {anchor_y_next[COORD_WIDTH-1], anchor_y_next};
    adx = dx[COORD_WIDTH] ? -dx : dx;
    ady = dy[COORD_WIDTH] ? -dy : dy;
    drift = (cfg.move_threshold != '0) &&
            ((CMP_W'(adx) > CMP_W'(cfg.move_threshold)) ||
             (CMP_W'(ady) > CMP_W'(cfg.move_threshold)));
    elapsed = s.now_ms - start_time;

    if (do_check) begin
      if (!cin || drift) begin
        do_release = 1'b1;
      end else if (!hold_active) begin
        if (!timing) begin
          timing_next     = 1'b1;
          start_time_next = s.now_ms;
        end else if (elapsed >= TIME_W'(cfg.time_threshold)) begin
          timing_next      = 1'b0;
          start_time_next  = '0;
          hold_active_next = 1'b1;
          kind_next        = EV_START;
          ev_x_next        = cx;
          ev_y_next        = cy;
        end
      end
    end

    if (do_release) begin
      timing_next      = 1'b0;
      start_time_next  = '0;
      hold_active_next = 1'b0;
      if (hold_active) begin
        kind_next = EV_RELEASE;
        ev_x_next = cx;
        ev_y_next = cy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_active <= 1'b0;
      timing      <= 1'b0;
      start_time  <= '0;
      anchor_x    <= '0;
      anchor_y    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (s.ready) begin
        out_valid <= s.valid;
      end
      if (advance) begin
        hold_active <= hold_active_next;
        timing      <= timing_next;
        start_time  <= start_time_next;
        anchor_x    <= anchor_x_next;
        anchor_y    <= anchor_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m.event_kind <= kind_next;
      m.event_x    <= ev_x_next;
      m.event_y    <= ev_y_next;
      m.recognized <= hold_active_next;
    end
  end

endmodule

// ===== hw/rtl/long_press_detector_unit.sv =====
// Long-press detector. Touch events (begin, move, cancel, end, tick) enter on
// in_ch with a position, a millisecond timestamp and the node hit-test flag;
// every accepted event produces exactly one result on out_ch: hold started,
// hold released or no event, plus the current recognized flag. A begin inside
// the node anchors the press and starts timing; once now_ms minus the start
// time (wrapping 32-bit) reaches time_threshold a hold starts. Leaving the
// node, cancel, end, or drifting more than move_threshold pixels on either
// axis from the anchor releases it (move_threshold 0 turns the drift check
// off). Throughput is one event per clock while out_ch accepts results;
// each event passes the input register and then the result register, and
// the decision logic between them (one 32-bit subtract-compare and two
// coordinate compares) is the critical path. Registers: time_threshold at
// byte address 0 (reset 750), move_threshold at address 4 (reset 0). Write
// them only while no event is in flight.
module long_press_detector_unit
  import lpd_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  lpd_in_if.sink            in_ch,
  lpd_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // staged event between input register and decision logic
  lpd_in_if #(.COORD_WIDTH(COORD_WIDTH)) stage_ch ();

  lpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // register the incoming transfer
  lpd_in_stage u_in_stage (
    .clk (clk),
    .rst (rst),
    .s   (in_ch),
    .m   (stage_ch)
  );

  // advance press state and register the result
  lpd_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .s   (stage_ch),
    .m   (out_ch)
  );

endmodule
